// File: rtl/core/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes of the min-priority queue: opcodes, result status
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int KEY_W        = 32;
  localparam int OCC_W        = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_MOVE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    scan_clr;
    logic    ins_wr;
    logic    scan_rd;
    logic    last_rd;
    logic    move_wr;
    logic    load_out;
    status_t res_status;
  } mpq_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic scan_last;
  } mpq_sts_t;

endpackage

// File: rtl/core/mpq_datapath.sv
// ----------------------------------------------------------------------------
// mpq_datapath
// Key store memory, occupancy counter, minimum search registers and the
// result register of the min-priority queue.
// ----------------------------------------------------------------------------
module mpq_datapath #(
  parameter int CAPACITY = mpq_pkg::DEF_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mpq_pkg::mpq_cmd_t               cmd,
  output mpq_pkg::mpq_sts_t               sts,
  input  logic signed [mpq_pkg::KEY_W-1:0] in_key,
  output mpq_pkg::status_t                res_status,
  output logic signed [mpq_pkg::KEY_W-1:0] res_key,
  output logic [mpq_pkg::OCC_W-1:0]       res_occ
);
  import mpq_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [KEY_W-1:0] mem [CAPACITY];

  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic [IW-1:0]           idx_r;
  logic [IW-1:0]           idx_q_r;
  logic                    rd_vld_r;
  logic signed [KEY_W-1:0] rd_data_r;
  logic [IW-1:0]           best_idx_r;
  logic signed [KEY_W-1:0] best_key_r;
  logic [IW-1:0]           last_idx;
  logic [IW-1:0]           rd_addr;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;
  logic                    take_new;
  status_t                 res_status_r;
  logic signed [KEY_W-1:0] res_key_r;
  logic [OCC_W-1:0]        res_occ_r;

  assign last_idx = IW'(count_r - CW'(1));
  assign rd_addr  = cmd.last_rd ? last_idx : idx_r;

  assign sts.cnt_zero  = (count_r == '0);
  assign sts.cnt_full  = (count_r >= CW'(CAPACITY));
  assign sts.scan_last = (idx_r == last_idx);

  always_comb begin
    wr_en   = cmd.ins_wr | cmd.move_wr;
    wr_addr = cmd.ins_wr ? count_r[IW-1:0] : best_idx_r;
    wr_data = cmd.ins_wr ? in_key : rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_wr) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.move_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // first beat of a scan always seeds the running minimum
  assign take_new = rd_vld_r && ((idx_q_r == '0) || (rd_data_r < best_key_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      count_r  <= count_nxt;
      rd_vld_r <= cmd.scan_rd;
      if (cmd.scan_clr) begin
        idx_r <= '0;
      end else if (cmd.scan_rd) begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_q_r <= idx_r;
    if (take_new) begin
      best_idx_r <= idx_q_r;
      best_key_r <= rd_data_r;
    end
    if (cmd.load_out) begin
      res_status_r <= cmd.res_status;
      res_key_r    <= (cmd.res_status == ST_REMOVED) ? best_key_r : '0;
      res_occ_r    <= OCC_W'(count_r);
    end
  end

  assign res_status = res_status_r;
  assign res_key    = res_key_r;
  assign res_occ    = res_occ_r;

endmodule

// File: rtl/core/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// Controller of the min-priority queue: accepts one beat at a time, runs the
// minimum scan for a delete and hands the result to the output register.
// ----------------------------------------------------------------------------
module mpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_op,
  output logic                out_tvalid,
  input  logic                out_tready,
  output mpq_pkg::mpq_cmd_t   cmd,
  input  mpq_pkg::mpq_sts_t   sts
);
  import mpq_pkg::*;

  state_t  state_r;
  state_t  state_nxt;
  status_t st_r;
  status_t st_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    accept;
  logic    slot_free;

  assign accept    = (state_r == S_IDLE) && in_tvalid;
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (op_t'(in_op) == OP_INSERT) begin
            st_nxt    = sts.cnt_full ? ST_FULL : ST_INSERTED;
            state_nxt = S_FINISH;
          end else if (sts.cnt_zero) begin
            st_nxt    = ST_EMPTY;
            state_nxt = S_FINISH;
          end else begin
            st_nxt    = ST_REMOVED;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH:  state_nxt = S_MOVE;
      S_MOVE:   state_nxt = S_FINISH;
      S_FINISH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.res_status = st_r;
    in_tready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.scan_clr = 1'b1;
        cmd.ins_wr   = accept && (op_t'(in_op) == OP_INSERT) && !sts.cnt_full;
      end
      S_SCAN:   cmd.scan_rd  = 1'b1;
      S_FETCH:  cmd.last_rd  = 1'b1;
      S_MOVE:   cmd.move_wr  = 1'b1;
      S_FINISH: cmd.load_out = slot_free;
      default:  cmd          = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_INSERTED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: rtl/core/min_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// min_priority_queue_unit
// Bounded min-priority queue of signed 32-bit keys with insert and delete-min.
// ----------------------------------------------------------------------------
// Each input beat is an insert (tuser 0) or a delete-min (tuser 1) and yields
// one result beat with a status, the removed key and the occupancy after the
// beat. Keys sit unordered in a CAPACITY-entry single-port-write memory. A
// delete-min runs the linear minimum scan that reads one memory entry per
// cycle, then moves the last entry into the freed slot. One beat is in work
// at a time; a finished result waits in the output register while the next
// input beat is taken. Reset needs no clearing pass.
module min_priority_queue_unit #(
  parameter int CAPACITY = mpq_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key
  input  logic [0:0]  in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] min_key, [36:32] occupancy, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import mpq_pkg::*;

  mpq_cmd_t                cmd;
  mpq_sts_t                sts;
  status_t                 res_status;
  logic signed [KEY_W-1:0] res_key;
  logic [OCC_W-1:0]        res_occ;

  mpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_key     (in_tdata),
    .res_status (res_status),
    .res_key    (res_key),
    .res_occ    (res_occ)
  );

  assign out_tdata = {3'b000, res_occ, res_key};
  assign out_tuser = res_status;

endmodule
